FILE: src/ict_pkg.sv
package ict_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int NSTEPS       = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int SQRT_STEPS   = 24;
    localparam int DIV_CHUNKS   = 4;
    localparam int DIV_STEPS    = 2 * DIV_CHUNKS;
    localparam int TILT_LAST    = SQRT_STEPS + NSTEPS - 1;
    localparam int RUN_LAST     = (TILT_LAST > DIV_STEPS - 1) ? TILT_LAST : DIV_STEPS - 1;
    localparam int CNT_W        = $clog2(RUN_LAST + 1);
    localparam int DIVISOR      = 16375;
    localparam int DIV_OFFSET   = 8187;
    localparam int DIV_SHIFT    = 44;
    localparam logic [30:0] DIV_RECIP = 31'((64'd1 << DIV_SHIFT) / 64'(DIVISOR));
    localparam logic [15:0] BLEND_RESET = 16'd62915;

    typedef enum logic [7:0] {
        REG_BIAS_X = 8'd0,
        REG_BIAS_Y = 8'd1,
        REG_BIAS_Z = 8'd2,
        REG_BLEND  = 8'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_RUN,
        S_INT,
        S_BLEND,
        S_SUM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic        [31:0] time_ms;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] fused_x;
        logic signed [31:0] fused_y;
        logic signed [31:0] fused_z;
        logic signed [31:0] drift_x;
        logic signed [31:0] drift_y;
        logic signed [31:0] drift_z;
    } t_result;

    typedef struct packed {
        logic [2:0][15:0] accel;
        logic [2:0][16:0] rate;
        logic [31:0]      dt;
    } t_job;

    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/ict_front.sv
module ict_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ict_pkg::t_sample i_item,
    input  logic             push,
    output logic             full,
    input  logic             valid,
    output logic             ready,
    input  logic [7:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    output ict_pkg::t_job    o_job,
    output logic             o_job_push,
    input  logic             i_job_full,
    output logic [15:0]      o_blend_weight
);
    import ict_pkg::*;

    logic        [31:0] r_prev_time;
    logic signed [15:0] r_bias_x, r_bias_y, r_bias_z;
    logic        [15:0] r_blend;

    assign ready          = 1'b1;
    assign full           = i_job_full;
    assign o_job_push     = push && !i_job_full;
    assign o_blend_weight = r_blend;

    always_comb begin
        o_job.accel[0] = i_item.accel_x;
        o_job.accel[1] = i_item.accel_y;
        o_job.accel[2] = i_item.accel_z;
        o_job.rate[0]  = {i_item.rate_x[15], i_item.rate_x} - {r_bias_x[15], r_bias_x};
        o_job.rate[1]  = {i_item.rate_y[15], i_item.rate_y} - {r_bias_y[15], r_bias_y};
        o_job.rate[2]  = {i_item.rate_z[15], i_item.rate_z} - {r_bias_z[15], r_bias_z};
        o_job.dt       = i_item.time_ms - r_prev_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_bias_x    <= '0;
            r_bias_y    <= '0;
            r_bias_z    <= '0;
            r_blend     <= BLEND_RESET;
        end else begin
            if (valid && ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_BIAS_X: r_bias_x <= i_cfg_data;
                    REG_BIAS_Y: r_bias_y <= i_cfg_data;
                    REG_BIAS_Z: r_bias_z <= i_cfg_data;
                    REG_BLEND:  r_blend  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_job_push) begin
                r_prev_time <= i_item.time_ms;
            end
        end
    end

endmodule

FILE: src/ict_queue.sv
module ict_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ict_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output ict_pkg::t_job o_data,
    output logic          o_empty
);
    import ict_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= !r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0) - 2'((i_pop && !o_empty) ? 1 : 0);
        end
    end

endmodule

FILE: src/ict_back.sv
module ict_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ict_pkg::t_job    i_job,
    input  logic             i_job_empty,
    output logic             o_job_pop,
    input  logic [15:0]      i_blend_weight,
    output ict_pkg::t_result o_result,
    output logic             empty,
    input  logic             pop
);
    import ict_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic                 out_load;
    t_job                 r_job;

    logic signed [49:0]   r_prod [3];
    logic        [30:0]   r_sq   [3];
    logic        [63:0]   r_num  [3], n_num [3];
    logic        [13:0]   r_rem  [3], n_rem [3];
    logic        [15:0]   r_qe   [3], n_qe  [3];
    logic                 r_neg  [3];

    logic        [47:0]   r_sv   [2];
    logic        [25:0]   r_srem [2], n_srem [2];
    logic        [23:0]   r_root [2], n_root [2];
    logic signed [27:0]   r_cx   [2], r_cy [2], n_cx [2], n_cy [2];
    logic signed [23:0]   r_cz   [2], n_cz [2];
    logic                 r_zero [2];
    logic signed [23:0]   ang    [2];

    logic signed [31:0]   r_gi    [3];
    logic signed [31:0]   r_fused [3];
    logic signed [31:0]   r_drift [3];
    logic signed [48:0]   dinc    [3];
    logic signed [49:0]   r_pw    [2], r_pa [2];
    logic signed [31:0]   blend_v [2];
    logic signed [31:0]   sqf     [3];

    t_result              r_out;
    logic                 r_out_vld;

    logic                 div_on, sqrt_on, cordic_on;
    logic [4:0]           ci;
    logic [31:0]          sum_r, sum_p;
    logic [49:0]          mag [3];
    logic [16:0]          pnum;
    logic [16:0]          accel_w;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -51'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (!i_job_empty) n_state = S_MUL;
            S_MUL:   n_state = S_PREP;
            S_PREP:  n_state = S_RUN;
            S_RUN:   if (r_cnt == CNT_W'(RUN_LAST)) n_state = S_INT;
            S_INT:   n_state = S_BLEND;
            S_BLEND: n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT:   if (!r_out_vld || pop) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = (r_state == S_IDLE) && !i_job_empty;
        out_load  = (r_state == S_OUT) && (!r_out_vld || pop);
        div_on    = (r_state == S_RUN) && (r_cnt <= CNT_W'(DIV_STEPS - 1));
        sqrt_on   = (r_state == S_RUN) && (r_cnt <= CNT_W'(SQRT_STEPS - 1));
        cordic_on = (r_state == S_RUN) && (r_cnt >= CNT_W'(SQRT_STEPS))
                    && (r_cnt <= CNT_W'(TILT_LAST));
    end

    assign ci       = 5'(r_cnt - CNT_W'(SQRT_STEPS));
    assign sum_r    = {1'b0, r_sq[0]} + {1'b0, r_sq[2]};
    assign sum_p    = {1'b0, r_sq[1]} + {1'b0, r_sq[2]};
    assign pnum     = -{r_job.accel[0][15], r_job.accel[0]};
    assign accel_w  = 17'(18'd65536 - {2'b00, i_blend_weight});

    always_comb begin
        logic [29:0] xv, diff;
        logic [60:0] rp;
        logic [15:0] qn;
        logic [27:0] rt, trial;
        logic signed [27:0] xs, ys;
        for (int k = 0; k < 3; k++) begin
            sqf[k]  = $signed(r_job.accel[k]) * $signed(r_job.accel[k]);
            mag[k]  = r_prod[k][49] ? 50'(-r_prod[k]) : r_prod[k];
            dinc[k] = r_neg[k] ? -$signed({1'b0, r_num[k][47:0]})
                               : $signed({1'b0, r_num[k][47:0]});
            xv      = {r_rem[k], r_num[k][63:48]};
            rp      = 61'(xv) * 61'(DIV_RECIP);
            n_qe[k] = 16'(rp >> DIV_SHIFT);
            diff    = xv - 30'(r_qe[k]) * 30'(DIVISOR);
            if (diff >= 30'(DIVISOR)) begin
                qn       = r_qe[k] + 16'd1;
                n_rem[k] = 14'(diff - 30'(DIVISOR));
            end else begin
                qn       = r_qe[k];
                n_rem[k] = diff[13:0];
            end
            n_num[k] = {r_num[k][47:0], qn};
        end
        for (int l = 0; l < 2; l++) begin
            rt    = {r_srem[l], r_sv[l][47:46]};
            trial = {2'b00, r_root[l], 2'b01};
            if (rt >= trial) begin
                n_srem[l] = 26'(rt - trial);
                n_root[l] = {r_root[l][22:0], 1'b1};
            end else begin
                n_srem[l] = rt[25:0];
                n_root[l] = {r_root[l][22:0], 1'b0};
            end
            xs = r_cx[l] >>> ci;
            ys = r_cy[l] >>> ci;
            if (r_cy[l] >= 0) begin
                n_cx[l] = r_cx[l] + ys;
                n_cy[l] = r_cy[l] - xs;
                n_cz[l] = r_cz[l] + $signed({2'b00, atan_entry(ci)});
            end else begin
                n_cx[l] = r_cx[l] - ys;
                n_cy[l] = r_cy[l] + xs;
                n_cz[l] = r_cz[l] - $signed({2'b00, atan_entry(ci)});
            end
            ang[l] = r_zero[l] ? 24'sd0 : r_cz[l];
            blend_v[l] = sat32(($signed({r_pw[l][49], r_pw[l]})
                               + $signed({r_pa[l][49], r_pa[l]})
                               + 51'sd32768) >>> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (r_state == S_MUL) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= $signed(r_job.rate[k]) * $signed({1'b0, r_job.dt});
                r_sq[k]   <= sqf[k][30:0];
            end
        end
        if (r_state == S_PREP) begin
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= r_prod[k][49];
                r_num[k] <= {3'b000, mag[k][47:0], 13'b0} + 64'(DIV_OFFSET);
                r_rem[k] <= '0;
            end
            r_sv[0]   <= {sum_r, 16'b0};
            r_sv[1]   <= {sum_p, 16'b0};
            r_cy[0]   <= $signed({{4{r_job.accel[1][15]}}, r_job.accel[1], 8'b0});
            r_cy[1]   <= $signed({{3{pnum[16]}}, pnum, 8'b0});
            r_zero[0] <= (sum_r == '0) && (r_job.accel[1] == '0);
            r_zero[1] <= (sum_p == '0) && (r_job.accel[0] == '0);
            for (int l = 0; l < 2; l++) begin
                r_srem[l] <= '0;
                r_root[l] <= '0;
                r_cz[l]   <= '0;
            end
        end
        if (div_on && !r_cnt[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_qe[k] <= n_qe[k];
            end
        end
        if (div_on && r_cnt[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= n_num[k];
                r_rem[k] <= n_rem[k];
            end
        end
        if (sqrt_on) begin
            for (int l = 0; l < 2; l++) begin
                r_sv[l]   <= {r_sv[l][45:0], 2'b00};
                r_srem[l] <= n_srem[l];
                r_root[l] <= n_root[l];
                r_cx[l]   <= $signed({4'b0000, n_root[l]});
            end
        end
        if (cordic_on) begin
            for (int l = 0; l < 2; l++) begin
                r_cx[l] <= n_cx[l];
                r_cy[l] <= n_cy[l];
                r_cz[l] <= n_cz[l];
            end
        end
        if (r_state == S_INT) begin
            for (int k = 0; k < 3; k++) begin
                r_gi[k] <= sat32({{19{r_fused[k][31]}}, r_fused[k]} + {{2{dinc[k][48]}}, dinc[k]});
            end
        end
        if (r_state == S_BLEND) begin
            for (int l = 0; l < 2; l++) begin
                r_pw[l] <= $signed({2'b00, i_blend_weight}) * r_gi[l];
                r_pa[l] <= $signed({1'b0, accel_w}) * ang[l];
            end
        end
        if (out_load) begin
            r_out.fused_x <= r_fused[0];
            r_out.fused_y <= r_fused[1];
            r_out.fused_z <= r_fused[2];
            r_out.drift_x <= r_drift[0];
            r_out.drift_y <= r_drift[1];
            r_out.drift_z <= r_drift[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_fused[k] <= '0;
                r_drift[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_RUN) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (r_state == S_INT) begin
                for (int k = 0; k < 3; k++) begin
                    r_drift[k] <= sat32({{19{r_drift[k][31]}}, r_drift[k]}
                                        + {{2{dinc[k][48]}}, dinc[k]});
                end
            end
            if (r_state == S_SUM) begin
                r_fused[0] <= blend_v[0];
                r_fused[1] <= blend_v[1];
                r_fused[2] <= r_gi[2];
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_result = r_out;
    assign empty    = !r_out_vld;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_cnt <= CNT_W'(RUN_LAST))
        else $error("run counter past last step");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> (r_rem[0] < 14'(DIVISOR)) && (r_rem[1] < 14'(DIVISOR))
                             && (r_rem[2] < 14'(DIVISOR)))
        else $error("divider remainder out of range");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !pop |=> r_out_vld)
        else $error("result dropped");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> r_state == S_MUL)
        else $error("item taken outside idle");

endmodule

FILE: src/imu_complementary_tilt_filter.sv
// Complementary tilt filter for one IMU sample stream.
// Input channel: drive i_item and raise push; the item is taken at a clock edge
// where push is high and full is low. A two-entry queue holds items ahead of
// the compute engine, so up to two samples can be taken while one is in work.
// Result channel: while empty is low, o_result holds the oldest result; raise
// pop to take it. A finished result waits in an output register, and the
// engine finishes the next item behind it, then holds until the register frees.
// Configuration: valid/i_cfg_index/i_cfg_data, always ready; index 0..2 are the
// gyro biases, 3 the gyro blend weight. Write only while the block is idle.
// Engine: each item passes through setup (multiply, then prepare), then a run
// phase of 24 square-root steps followed by CORDIC_STEPS arctangent steps (the
// angle-step divider runs alongside: a reciprocal multiply and a correction for
// each of four 16-bit chunks), then integration, blend, sum and output. The
// engine takes the next item only when done with the last. The square root plus CORDIC chain sets the rate.
// Reset: synchronous, active low; clears angles, the previous timestamp, the
// queue and the result register, and loads the default bias and weight values.
module imu_complementary_tilt_filter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ict_pkg::t_sample i_item,
    input  logic             push,
    output logic             full,
    output ict_pkg::t_result o_result,
    output logic             empty,
    input  logic             pop,
    input  logic             valid,
    output logic             ready,
    input  logic [7:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data
);
    import ict_pkg::*;

    t_job        f_job, q_job;
    logic        f_push, q_full, q_empty, b_pop;
    logic [15:0] blend_weight;

    ict_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .push           (push),
        .full           (full),
        .valid          (valid),
        .ready          (ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_job          (f_job),
        .o_job_push     (f_push),
        .i_job_full     (q_full),
        .o_blend_weight (blend_weight)
    );

    ict_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_job),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    ict_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (q_job),
        .i_job_empty    (q_empty),
        .o_job_pop      (b_pop),
        .i_blend_weight (blend_weight),
        .o_result       (o_result),
        .empty          (empty),
        .pop            (pop)
    );

endmodule

FILE: verif/tb_imu_complementary_tilt_filter.sv
module tb_imu_complementary_tilt_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import ict_pkg::*;

    localparam int LATENCY = 64;

    logic i_clk;
    logic i_rst_n;
    t_sample i_item;
    logic push;
    logic full;
    t_result o_result;
    logic empty;
    logic pop;
    logic valid;
    logic ready;
    logic [7:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    int errors = 0;
    int send_idle = 0;
    int recv_stall = 0;

    imu_complementary_tilt_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .push(push), .full(full),
        .o_result(o_result), .empty(empty), .pop(pop), .valid(valid), .ready(ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    class tilt_scoreboard;
        logic [31:0] last_time;
        logic signed [31:0] fused[3];
        logic signed [31:0] drift[3];
        logic signed [15:0] bias[3];
        logic [15:0] alpha;
        t_result angle_q[$];

        function void clear();
            last_time = '0;
            foreach (fused[k]) begin
                fused[k] = '0;
                drift[k] = '0;
                bias[k] = '0;
            end
            alpha = BLEND_RESET;
            angle_q.delete();
        endfunction

        function void write_reg(t_cfg_reg idx, logic [15:0] data);
            case (idx)
                REG_BIAS_X: bias[0] = data;
                REG_BIAS_Y: bias[1] = data;
                REG_BIAS_Z: bias[2] = data;
                REG_BLEND: alpha = data;
                default: ;
            endcase
        endfunction

        function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function longint tilt(longint num, longint p, longint q);
            longint x, y, z, xs, ys;
            longint unsigned sq;
            sq = longint'(p * p) + longint'(q * q);
            x = root(sq << 16);
            y = num * 256;
            z = 0;
            if (x == 0 && y == 0) return 0;
            for (int i = 0; i < NSTEPS; i++) begin
                xs = floor_shift(x, i);
                ys = floor_shift(y, i);
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z += longint'(atan_entry(5'(i)));
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z -= longint'(atan_entry(5'(i)));
                end
            end
            return z;
        endfunction

        function longint angle_step(longint r, logic [31:0] dt);
            longint p;
            longint unsigned m, q;
            p = r * longint'({32'd0, dt});
            m = (p < 0) ? longint'(-p) : p;
            q = (m * 8192 + DIV_OFFSET) / DIVISOR;
            return (p < 0) ? -longint'(q) : longint'(q);
        endfunction

        function logic signed [31:0] mix(longint g, longint a);
            longint w;
            w = longint'({48'd0, alpha});
            return 32'(clip32(floor_shift(w * g + (65536 - w) * a + 32768, 16)));
        endfunction

        function void note_sample(t_sample s);
            logic [31:0] dt;
            longint roll, pitch, d, ax, ay, az;
            logic signed [31:0] gsum[3];
            logic signed [15:0] raw[3];
            t_result r;
            ax = s.accel_x;
            ay = s.accel_y;
            az = s.accel_z;
            raw[0] = s.rate_x;
            raw[1] = s.rate_y;
            raw[2] = s.rate_z;
            dt = s.time_ms - last_time;
            roll = tilt(ay, ax, az);
            pitch = tilt(-ax, ay, az);
            for (int k = 0; k < 3; k++) begin
                d = angle_step(longint'(raw[k]) - longint'(bias[k]), dt);
                gsum[k] = 32'(clip32(longint'(fused[k]) + d));
                drift[k] = 32'(clip32(longint'(drift[k]) + d));
            end
            fused[0] = mix(gsum[0], roll);
            fused[1] = mix(gsum[1], pitch);
            fused[2] = gsum[2];
            last_time = s.time_ms;
            r.fused_x = fused[0];
            r.fused_y = fused[1];
            r.fused_z = fused[2];
            r.drift_x = drift[0];
            r.drift_y = drift[1];
            r.drift_z = drift[2];
            angle_q.push_back(r);
        endfunction

        task check_result(t_result got);
            t_result w;
            if (angle_q.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
                return;
            end
            w = angle_q.pop_front();
            if (got.fused_x !== w.fused_x) report_mismatch("fused_x", got.fused_x, w.fused_x);
            if (got.fused_y !== w.fused_y) report_mismatch("fused_y", got.fused_y, w.fused_y);
            if (got.fused_z !== w.fused_z) report_mismatch("fused_z", got.fused_z, w.fused_z);
            if (got.drift_x !== w.drift_x) report_mismatch("drift_x", got.drift_x, w.drift_x);
            if (got.drift_y !== w.drift_y) report_mismatch("drift_y", got.drift_y, w.drift_y);
            if (got.drift_z !== w.drift_z) report_mismatch("drift_z", got.drift_z, w.drift_z);
        endtask
    endclass

    tilt_scoreboard board;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) board.check_result(o_result);
            pop <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic write_reg(t_cfg_reg idx, logic [15:0] data);
        valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!ready) @(posedge i_clk);
        board.write_reg(idx, data);
        valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(t_sample s);
        int idle_draw;
        idle_draw = $urandom_range(99);
        if (idle_draw < send_idle) begin
            push <= 1'b0;
            while (idle_draw < send_idle) begin
                @(posedge i_clk);
                idle_draw = $urandom_range(99);
            end
        end
        push <= 1'b1;
        i_item <= s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_sample(s);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (board.angle_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(int count, logic [31:0] now);
        t_sample s;
        for (int n = 0; n < count; n++) begin
            s.accel_x = pick16();
            s.accel_y = pick16();
            s.accel_z = ($urandom_range(3) == 0) ? pick16() : 16'(16384 + $urandom_range(800));
            s.rate_x = pick16();
            s.rate_y = pick16();
            s.rate_z = pick16();
            case ($urandom_range(19))
                0: now = $urandom;
                1: now = now - $urandom_range(50);
                default: now = now + $urandom_range(20);
            endcase
            s.time_ms = now;
            send_sample(s);
        end
    endtask

    initial begin
        t_sample s;
        board = new();
        board.clear();
        i_rst_n = 0;
        push = 0;
        pop = 0;
        valid = 0;
        i_item = '0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        s = '0;
        s.time_ms = 32'd10;
        send_sample(s);
        s.accel_x = 16'sh7fff;
        s.accel_y = 16'sh8000;
        s.accel_z = 16'sh8000;
        s.rate_x = 16'sh7fff;
        s.rate_y = 16'sh8000;
        s.rate_z = 16'sh7fff;
        s.time_ms = 32'd20;
        send_sample(s);
        s = '0;
        s.accel_z = 16'sd1000;
        s.time_ms = 32'd5;
        send_sample(s);
        s.accel_x = 16'sd500;
        s.accel_z = 16'sd0;
        s.time_ms = 32'hffff_fff0;
        send_sample(s);
        s.accel_x = 16'sd0;
        s.accel_y = -16'sd300;
        s.rate_x = 16'sh7fff;
        s.rate_y = 16'sh8000;
        s.rate_z = 16'sh7fff;
        s.time_ms = 32'h7fff_ff00;
        send_sample(s);
        for (int n = 0; n < 4; n++) begin
            s.time_ms = s.time_ms + 32'h7fff_ffff;
            send_sample(s);
        end
        s.accel_x = 16'hffff;
        s.accel_y = 16'hffff;
        s.accel_z = 16'hffff;
        s.rate_x = 16'hffff;
        s.rate_y = 16'hffff;
        s.rate_z = 16'hffff;
        s.time_ms = 32'hffff_ffff;
        send_sample(s);
        drain();

        write_reg(REG_BIAS_X, 16'h8000);
        write_reg(REG_BIAS_Y, 16'h7fff);
        write_reg(REG_BIAS_Z, 16'd25);
        write_reg(REG_BLEND, 16'd0);
        send_random(30, 32'd100);
        drain();
        write_reg(REG_BLEND, 16'hffff);
        write_reg(REG_BIAS_X, 16'hffff);
        send_random(30, 32'd4000);
        drain();
        write_reg(REG_BIAS_X, 16'd0);
        write_reg(REG_BIAS_Y, 16'd0);
        write_reg(REG_BIAS_Z, 16'd0);
        write_reg(REG_BLEND, BLEND_RESET);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 76; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 76; end
                default: begin send_idle = 14; recv_stall = 14; end
            endcase
            write_reg(REG_BIAS_X, 16'($urandom_range(200)) - 16'd100);
            write_reg(REG_BLEND, 16'($urandom));
            send_random(80, $urandom);
            drain();
            send_random(80, $urandom);
            drain();
        end
        send_idle = 0;
        recv_stall = 0;
        send_random(30, 32'd0);

        fork
            drain();
            begin
                repeat (200000) @(posedge i_clk);
            end
        join_any
        disable fork;
        if (errors == 0 && board.angle_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: files.f
src/ict_pkg.sv
src/ict_front.sv
src/ict_queue.sv
src/ict_back.sv
src/imu_complementary_tilt_filter.sv
verif/tb_imu_complementary_tilt_filter.sv
